FILE: sv/olpht_pkg.sv
// ----------------------------------------------------------------------------
// olpht_pkg
// Types, codes and constants shared by the ordered linear-probe hash table.
// ----------------------------------------------------------------------------
package olpht_pkg;

   localparam int TABLE_LOG2 = 8;
   localparam int SLOTS      = 1 << TABLE_LOG2;
   localparam int IDX_W      = TABLE_LOG2;
   localparam int CNT_W      = TABLE_LOG2 + 1;
   localparam int TAG_W      = 16;
   localparam int FRAC_BITS  = 7;
   localparam int HASH_W     = 64;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;

   // tag layout: exist bit, 8 home-index bits, 7 fraction bits
   localparam int ORDER_POS     = 14;
   localparam int IDX_ORDER_POS = 7;
   localparam logic [7:0] MAX_OFFSET = 8'h80;

   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ABSENT   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [HASH_W-1:0] hash_word;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    slot_index;
      logic [VAL_W-1:0]    read_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE_RD, S_ORDER_CHK, S_MATCH_RD, S_MATCH_CHK,
      S_FWD_RD, S_FWD_CHK, S_SHIFT_RD, S_SHIFT_WR, S_BACK_RD, S_BACK_CHK
   } state_type;

   typedef enum logic [1:0] {PTR_HOLD, PTR_HOME, PTR_INC, PTR_DEC} ptr_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_ONE, CNT_INC} cnt_op_type;
   typedef enum logic [1:0] {RD_PTR, RD_PREV, RD_NEXT} rd_sel_type;
   typedef enum logic [2:0] {WR_NONE, WR_VALUE, WR_COPY, WR_NEW, WR_CLEAR} wr_op_type;
   typedef enum logic [1:0] {OCC_HOLD, OCC_INC, OCC_DEC} occ_op_type;
   typedef enum logic [2:0] {
      RSP_NONE, RSP_HIT, RSP_INSERTED, RSP_REMOVED, RSP_ABSENT, RSP_FULL
   } rsp_sel_type;

   typedef struct packed {
      logic        load;
      ptr_op_type  ptr_op;
      cnt_op_type  cnt_op;
      logic        save_pos;
      logic        save_rv;
      rd_sel_type  rd_sel;
      wr_op_type   wr_op;
      occ_op_type  occ_op;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic occ_full;
      logic precedes;
      logic tag_eq;
      logic key_eq;
      logic off_inv_k;
      logic off_inv_next;
      logic tag_zero;
      logic cnt_full;
      logic at_pos;
      logic last_shift;
      logic valid_next;
   } stat_type;

endpackage

FILE: sv/ordered_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// ordered_linear_probe_hash_table
// 256-slot linear-probe hash table with clusters kept sorted by tag.
//
// Usage: drive req_data and raise start; the request transfers on a clock
// edge where start is high and busy is low. busy stays high until the
// result is registered. Exactly one result per request appears on rsp_data,
// flagged by rsp_strobe for a single cycle; the receiver must take it then,
// as there is no back-pressure.
// Each slot read presents an address, then takes registered read data
// from the tag/key/value stores, each with one write and one read port.
// A find reads slots from the home slot until its answer is known. An
// insert scans slots up to and including the first empty slot, shifts
// entries forward and ends with one final write; an insert into a
// saturated table answers without scanning any slot. A remove shifts
// entries back and then clears the last slot of the run. busy is low
// while rsp_strobe is high, so the next request can transfer at the edge
// that ends the strobe cycle.
// Reset clears all tag valid bits and the occupancy count; the table is
// empty and ready immediately after reset.
// ----------------------------------------------------------------------------
module ordered_linear_probe_hash_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  olpht_pkg::req_type req_data,
   output logic               rsp_strobe,
   output olpht_pkg::rsp_type rsp_data
);

   olpht_pkg::cmd_type  cmd;
   olpht_pkg::stat_type stat;

   olpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   olpht_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_data   (rsp_data),
      .rsp_strobe (rsp_strobe)
   );

endmodule

FILE: sv/olpht_dp.sv
// ----------------------------------------------------------------------------
// olpht_dp
// Datapath: request register, slot pointer and counters, tag/key/value
// stores with registered read, and the result register.
// ----------------------------------------------------------------------------
module olpht_dp (
   input  logic                clock,
   input  logic                reset,
   input  olpht_pkg::req_type  req_data,
   input  olpht_pkg::cmd_type  cmd,
   output olpht_pkg::stat_type stat,
   output olpht_pkg::rsp_type  rsp_data,
   output logic                rsp_strobe
);

   olpht_pkg::req_type req_ff;
   logic [olpht_pkg::IDX_W-1:0] ptr_ff, ptr_in, pos_ff, rd_addr;
   logic [olpht_pkg::CNT_W-1:0] cnt_ff, cnt_in, occ_ff, occ_in;
   logic [olpht_pkg::VAL_W-1:0] rv_ff;

   logic [olpht_pkg::TAG_W-1:0] tag_mem [olpht_pkg::SLOTS];
   logic [olpht_pkg::KEY_W-1:0] key_mem [olpht_pkg::SLOTS];
   logic [olpht_pkg::VAL_W-1:0] val_mem [olpht_pkg::SLOTS];
   logic [olpht_pkg::SLOTS-1:0] valid_ff;
   logic                        rd_valid_ff;
   logic [olpht_pkg::TAG_W-1:0] tag_q, rd_tag, k_tag, tag_diff, wr_tag;
   logic [olpht_pkg::KEY_W-1:0] key_q, wr_key;
   logic [olpht_pkg::VAL_W-1:0] val_q, wr_val;
   logic                        wr_tag_en, wr_key_en, wr_val_en;
   logic [olpht_pkg::IDX_W-1:0] ptr_inc, ptr_dec;
   logic [8:0]                  home_diff;

   olpht_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_strobe_ff;

   assign ptr_inc = ptr_ff + 1'b1;
   assign ptr_dec = ptr_ff - 1'b1;
   assign k_tag   = {1'b1, req_ff.hash_word[olpht_pkg::HASH_W-1 -: olpht_pkg::TAG_W-1]};
   // a slot whose valid bit is clear reads as an empty tag
   assign rd_tag  = rd_valid_ff ? tag_q : '0;
   assign tag_diff  = rd_tag - k_tag;
   assign home_diff = {1'b0, ptr_ff} - rd_tag[olpht_pkg::TAG_W-1:olpht_pkg::FRAC_BITS];

   always_comb begin
      stat.func         = req_ff.func;
      stat.occ_full     = occ_ff[olpht_pkg::CNT_W-1];
      stat.cnt_full     = cnt_ff[olpht_pkg::CNT_W-1];
      stat.precedes     = !cnt_ff[olpht_pkg::CNT_W-1] && (rd_tag != '0)
                          && tag_diff[olpht_pkg::ORDER_POS];
      stat.tag_eq       = !cnt_ff[olpht_pkg::CNT_W-1] && (rd_tag == k_tag);
      stat.key_eq       = (key_q == req_ff.key);
      stat.off_inv_k    = ptr_ff == (k_tag[14:7] + olpht_pkg::MAX_OFFSET);
      stat.off_inv_next = ptr_inc == (rd_tag[14:7] + olpht_pkg::MAX_OFFSET);
      stat.tag_zero     = (rd_tag == '0);
      stat.at_pos       = (ptr_ff == pos_ff);
      stat.last_shift   = (cnt_ff == olpht_pkg::CNT_W'(olpht_pkg::SLOTS - 1));
      stat.valid_next   = (rd_tag[olpht_pkg::TAG_W-1:olpht_pkg::FRAC_BITS] != '0)
                          && !home_diff[olpht_pkg::IDX_ORDER_POS];
   end

   always_comb begin
      unique case (cmd.rd_sel)
         olpht_pkg::RD_PREV: rd_addr = ptr_dec;
         olpht_pkg::RD_NEXT: rd_addr = ptr_inc;
         default:            rd_addr = ptr_ff;
      endcase
   end

   always_comb begin
      wr_tag_en = 1'b0;
      wr_key_en = 1'b0;
      wr_val_en = 1'b0;
      wr_tag    = rd_tag;
      wr_key    = key_q;
      wr_val    = val_q;
      unique case (cmd.wr_op)
         olpht_pkg::WR_VALUE: begin
            wr_val_en = 1'b1;
            wr_val    = req_ff.entry_value;
         end
         olpht_pkg::WR_COPY: begin
            wr_tag_en = 1'b1;
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
         end
         olpht_pkg::WR_NEW: begin
            wr_tag_en = 1'b1;
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_tag    = k_tag;
            wr_key    = req_ff.key;
            wr_val    = req_ff.entry_value;
         end
         olpht_pkg::WR_CLEAR: begin
            wr_tag_en = 1'b1;
            wr_tag    = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_tag_en) tag_mem[ptr_ff] <= wr_tag;
      if (wr_key_en) key_mem[ptr_ff] <= wr_key;
      if (wr_val_en) val_mem[ptr_ff] <= wr_val;
      tag_q <= tag_mem[rd_addr];
      key_q <= key_mem[rd_addr];
      val_q <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_tag_en) valid_ff[ptr_ff] <= (wr_tag != '0);
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      unique case (cmd.ptr_op)
         olpht_pkg::PTR_HOME:
            ptr_in = req_data.hash_word[olpht_pkg::HASH_W-1 -: olpht_pkg::IDX_W];
         olpht_pkg::PTR_INC:  ptr_in = ptr_inc;
         olpht_pkg::PTR_DEC:  ptr_in = ptr_dec;
         default:             ptr_in = ptr_ff;
      endcase
      unique case (cmd.cnt_op)
         olpht_pkg::CNT_ZERO: cnt_in = '0;
         olpht_pkg::CNT_ONE:  cnt_in = olpht_pkg::CNT_W'(1);
         olpht_pkg::CNT_INC:  cnt_in = cnt_ff + 1'b1;
         default:             cnt_in = cnt_ff;
      endcase
      unique case (cmd.occ_op)
         olpht_pkg::OCC_INC: occ_in = occ_ff + 1'b1;
         olpht_pkg::OCC_DEC: occ_in = (occ_ff != '0) ? occ_ff - 1'b1 : occ_ff;
         default:            occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.save_pos) pos_ff <= ptr_ff;
      if (cmd.save_rv) rv_ff <= val_q;
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) occ_ff <= '0;
      else       occ_ff <= occ_in;
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.rsp_sel)
         olpht_pkg::RSP_HIT: begin
            rsp_in.status     = olpht_pkg::STAT_FOUND;
            rsp_in.slot_index = ptr_ff;
            rsp_in.read_value = val_q;
         end
         olpht_pkg::RSP_INSERTED: begin
            rsp_in.status     = olpht_pkg::STAT_INSERTED;
            rsp_in.slot_index = pos_ff;
         end
         olpht_pkg::RSP_REMOVED: begin
            rsp_in.status     = olpht_pkg::STAT_REMOVED;
            rsp_in.slot_index = pos_ff;
            rsp_in.read_value = rv_ff;
         end
         olpht_pkg::RSP_FULL: rsp_in.status = olpht_pkg::STAT_FULL;
         default:             rsp_in.status = olpht_pkg::STAT_ABSENT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_sel != olpht_pkg::RSP_NONE) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= (cmd.rsp_sel != olpht_pkg::RSP_NONE);
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

FILE: sv/olpht_ctrl.sv
// ----------------------------------------------------------------------------
// olpht_ctrl
// Controller: sequences probe, forward shift on insert and backward shift
// on remove.
// ----------------------------------------------------------------------------
module olpht_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  olpht_pkg::stat_type stat,
   output olpht_pkg::cmd_type  cmd,
   output logic                busy
);

   olpht_pkg::state_type state_ff, state_in;
   logic hit, is_ins, is_rem;

   assign hit    = stat.tag_eq && stat.key_eq;
   assign is_ins = (stat.func == olpht_pkg::FUNC_INSERT);
   assign is_rem = (stat.func == olpht_pkg::FUNC_REMOVE);
   assign busy   = (state_ff != olpht_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= olpht_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         olpht_pkg::S_IDLE:
            if (start) state_in = olpht_pkg::S_PROBE_RD;
         olpht_pkg::S_PROBE_RD:
            state_in = (is_ins && stat.occ_full) ? olpht_pkg::S_IDLE
                                                 : olpht_pkg::S_ORDER_CHK;
         olpht_pkg::S_MATCH_RD: state_in = olpht_pkg::S_MATCH_CHK;
         olpht_pkg::S_ORDER_CHK, olpht_pkg::S_MATCH_CHK: begin
            if (state_ff == olpht_pkg::S_ORDER_CHK && stat.precedes)
               state_in = olpht_pkg::S_PROBE_RD;
            else if (hit)
               state_in = is_rem ? olpht_pkg::S_BACK_RD : olpht_pkg::S_IDLE;
            else if (stat.tag_eq)
               state_in = olpht_pkg::S_MATCH_RD;
            else if (is_ins && !stat.off_inv_k)
               state_in = olpht_pkg::S_FWD_RD;
            else
               state_in = olpht_pkg::S_IDLE;
         end
         olpht_pkg::S_FWD_RD: state_in = olpht_pkg::S_FWD_CHK;
         olpht_pkg::S_FWD_CHK: begin
            if (stat.tag_zero) state_in = olpht_pkg::S_SHIFT_RD;
            else if (stat.off_inv_next || stat.cnt_full) state_in = olpht_pkg::S_IDLE;
            else state_in = olpht_pkg::S_FWD_RD;
         end
         olpht_pkg::S_SHIFT_RD:
            state_in = stat.at_pos ? olpht_pkg::S_IDLE : olpht_pkg::S_SHIFT_WR;
         olpht_pkg::S_SHIFT_WR: state_in = olpht_pkg::S_SHIFT_RD;
         olpht_pkg::S_BACK_RD:
            state_in = stat.last_shift ? olpht_pkg::S_IDLE : olpht_pkg::S_BACK_CHK;
         olpht_pkg::S_BACK_CHK:
            state_in = stat.valid_next ? olpht_pkg::S_BACK_RD : olpht_pkg::S_IDLE;
         default: state_in = olpht_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{load: 1'b0, ptr_op: olpht_pkg::PTR_HOLD, cnt_op: olpht_pkg::CNT_HOLD,
              save_pos: 1'b0, save_rv: 1'b0, rd_sel: olpht_pkg::RD_PTR,
              wr_op: olpht_pkg::WR_NONE, occ_op: olpht_pkg::OCC_HOLD,
              rsp_sel: olpht_pkg::RSP_NONE};
      unique case (state_ff)
         olpht_pkg::S_IDLE:
            if (start) begin
               cmd.load   = 1'b1;
               cmd.ptr_op = olpht_pkg::PTR_HOME;
               cmd.cnt_op = olpht_pkg::CNT_ZERO;
            end
         olpht_pkg::S_PROBE_RD:
            if (is_ins && stat.occ_full) cmd.rsp_sel = olpht_pkg::RSP_FULL;
         olpht_pkg::S_ORDER_CHK, olpht_pkg::S_MATCH_CHK: begin
            if (state_ff == olpht_pkg::S_ORDER_CHK && stat.precedes) begin
               cmd.ptr_op = olpht_pkg::PTR_INC;
               cmd.cnt_op = olpht_pkg::CNT_INC;
            end else if (hit) begin
               if (is_rem) begin
                  cmd.save_pos = 1'b1;
                  cmd.save_rv  = 1'b1;
                  cmd.cnt_op   = olpht_pkg::CNT_ZERO;
               end else begin
                  cmd.rsp_sel = olpht_pkg::RSP_HIT;
                  if (is_ins) cmd.wr_op = olpht_pkg::WR_VALUE;
               end
            end else if (stat.tag_eq) begin
               cmd.ptr_op = olpht_pkg::PTR_INC;
               cmd.cnt_op = olpht_pkg::CNT_INC;
            end else if (is_ins) begin
               cmd.save_pos = 1'b1;
               if (stat.off_inv_k) cmd.rsp_sel = olpht_pkg::RSP_FULL;
               else                cmd.cnt_op  = olpht_pkg::CNT_ONE;
            end else begin
               cmd.rsp_sel = olpht_pkg::RSP_ABSENT;
            end
         end
         olpht_pkg::S_FWD_CHK:
            if (!stat.tag_zero) begin
               if (stat.off_inv_next || stat.cnt_full) begin
                  cmd.rsp_sel = olpht_pkg::RSP_FULL;
               end else begin
                  cmd.ptr_op = olpht_pkg::PTR_INC;
                  cmd.cnt_op = olpht_pkg::CNT_INC;
               end
            end
         olpht_pkg::S_SHIFT_RD:
            if (stat.at_pos) begin
               cmd.wr_op   = olpht_pkg::WR_NEW;
               cmd.occ_op  = olpht_pkg::OCC_INC;
               cmd.rsp_sel = olpht_pkg::RSP_INSERTED;
            end else begin
               cmd.rd_sel = olpht_pkg::RD_PREV;
            end
         olpht_pkg::S_SHIFT_WR: begin
            cmd.wr_op  = olpht_pkg::WR_COPY;
            cmd.ptr_op = olpht_pkg::PTR_DEC;
         end
         olpht_pkg::S_BACK_RD:
            if (stat.last_shift) begin
               cmd.wr_op   = olpht_pkg::WR_CLEAR;
               cmd.occ_op  = olpht_pkg::OCC_DEC;
               cmd.rsp_sel = olpht_pkg::RSP_REMOVED;
            end else begin
               cmd.rd_sel = olpht_pkg::RD_NEXT;
            end
         olpht_pkg::S_BACK_CHK:
            if (stat.valid_next) begin
               cmd.wr_op  = olpht_pkg::WR_COPY;
               cmd.ptr_op = olpht_pkg::PTR_INC;
               cmd.cnt_op = olpht_pkg::CNT_INC;
            end else begin
               cmd.wr_op   = olpht_pkg::WR_CLEAR;
               cmd.occ_op  = olpht_pkg::OCC_DEC;
               cmd.rsp_sel = olpht_pkg::RSP_REMOVED;
            end
         default: ;
      endcase
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ordered linear-probe hash table against a behavioral table
// kept in the bench: directed cases, long clusters that reach the distance
// limit, a saturated table, then random traffic over a small key pool.
// ----------------------------------------------------------------------------
module testbench;

   // operation code with no defined meaning; behaves as a find
   localparam logic [olpht_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   olpht_pkg::req_type req_data = '0;
   logic               rsp_strobe;
   olpht_pkg::rsp_type rsp_data;

   ordered_linear_probe_hash_table uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // behavioral copy of the table
   logic [15:0]                 tags [olpht_pkg::SLOTS];
   logic [olpht_pkg::KEY_W-1:0] keys [olpht_pkg::SLOTS];
   logic [olpht_pkg::VAL_W-1:0] vals [olpht_pkg::SLOTS];
   int unsigned                 fill_count;

   olpht_pkg::rsp_type expected_rsp [$];
   int                 mismatches = 0;
   int                 rsp_seen = 0;
   int                 req_sent = 0;
   bit                 idle_on = 1'b0;
   int                 op_tally [5];

   // key pool for random traffic
   logic [olpht_pkg::KEY_W-1:0]  pool_key [64];
   logic [olpht_pkg::HASH_W-1:0] pool_hash [64];

   function automatic bit tag_before(int unsigned k, int unsigned c);
      return c != 0 && ((c - k) & 32'h4000) != 0;
   endfunction

   function automatic bit too_far(int unsigned slot, int unsigned t);
      return (slot & 8'hFF) == (((t >> olpht_pkg::FRAC_BITS) + 32'h80) & 8'hFF);
   endfunction

   function automatic bit fits_at(int unsigned slot, int unsigned t);
      int unsigned h;
      h = t >> olpht_pkg::FRAC_BITS;
      return h != 0 && (((slot & 8'hFF) - h) & 32'h80) == 0;
   endfunction

   function automatic bit lookup(int unsigned k, int unsigned home,
                                 logic [olpht_pkg::KEY_W-1:0] key,
                                 output int unsigned pos);
      int unsigned i, steps;
      i = home;
      steps = 0;
      while (steps < olpht_pkg::SLOTS && tag_before(k, tags[i])) begin
         i = (i + 1) % olpht_pkg::SLOTS;
         steps++;
      end
      while (steps < olpht_pkg::SLOTS && tags[i] == k) begin
         if (keys[i] == key) begin
            pos = i;
            return 1'b1;
         end
         i = (i + 1) % olpht_pkg::SLOTS;
         steps++;
      end
      pos = i;
      return 1'b0;
   endfunction

   function automatic olpht_pkg::rsp_type table_op(olpht_pkg::req_type r);
      olpht_pkg::rsp_type o;
      int unsigned        home, k, pos, mt, nxt, mv, n, i, pv;
      bit                 hit, full;
      home = 32'(r.hash_word[63 -: olpht_pkg::TABLE_LOG2]);
      k = 32'({1'b1, r.hash_word[63 -: (olpht_pkg::TABLE_LOG2 + olpht_pkg::FRAC_BITS)]});
      o = '0;
      o.status = olpht_pkg::STAT_ABSENT;
      if (r.func == olpht_pkg::FUNC_INSERT) begin
         if (fill_count >= olpht_pkg::SLOTS) begin
            o.status = olpht_pkg::STAT_FULL;
         end else if (lookup(k, home, r.key, pos)) begin
            o.read_value = vals[pos];
            vals[pos] = r.entry_value;
            o.status = olpht_pkg::STAT_FOUND;
            o.slot_index = 8'(pos);
         end else begin
            mt = k; nxt = pos; mv = pos; n = 0; full = 1'b0;
            do begin
               if (too_far(nxt, mt) || n >= olpht_pkg::SLOTS) begin
                  full = 1'b1;
                  break;
               end
               mv = nxt;
               mt = 32'(tags[mv]);
               nxt = (mv + 1) % olpht_pkg::SLOTS;
               n++;
            end while (mt != 0);
            if (full) begin
               o.status = olpht_pkg::STAT_FULL;
            end else begin
               while (mv != pos) begin
                  pv = (mv + olpht_pkg::SLOTS - 1) % olpht_pkg::SLOTS;
                  tags[mv] = tags[pv]; keys[mv] = keys[pv]; vals[mv] = vals[pv];
                  mv = pv;
               end
               tags[pos] = 16'(k); keys[pos] = r.key; vals[pos] = r.entry_value;
               fill_count++;
               o.status = olpht_pkg::STAT_INSERTED;
               o.slot_index = 8'(pos);
            end
         end
      end else if (r.func == olpht_pkg::FUNC_REMOVE) begin
         if (lookup(k, home, r.key, pos)) begin
            o.read_value = vals[pos];
            i = pos; n = 0;
            while (n + 1 < olpht_pkg::SLOTS) begin
               nxt = (i + 1) % olpht_pkg::SLOTS;
               if (!fits_at(i, 32'(tags[nxt]))) break;
               tags[i] = tags[nxt]; keys[i] = keys[nxt]; vals[i] = vals[nxt];
               i = nxt;
               n++;
            end
            tags[i] = '0;
            if (fill_count > 0) fill_count--;
            o.status = olpht_pkg::STAT_REMOVED;
            o.slot_index = 8'(pos);
         end
      end else begin
         hit = lookup(k, home, r.key, pos);
         if (hit) begin
            o.read_value = vals[pos];
            o.status = olpht_pkg::STAT_FOUND;
            o.slot_index = 8'(pos);
         end
      end
      return o;
   endfunction

   // one transfer: drive at the falling edge, wait for an edge with busy low
   task automatic send_request(olpht_pkg::req_type r);
      olpht_pkg::rsp_type want;
      @(negedge clock);
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      want = table_op(r);
      expected_rsp.push_back(want);
      op_tally[want.status]++;
      req_sent++;
      @(negedge clock);
      start <= 1'b0;
      if (idle_on && $urandom_range(3) == 0)
         repeat ($urandom_range(14, 1)) @(negedge clock);
   endtask

   function automatic olpht_pkg::req_type make_req(logic [olpht_pkg::FUNC_W-1:0] f,
                                                   logic [olpht_pkg::HASH_W-1:0] h,
                                                   logic [olpht_pkg::KEY_W-1:0] k,
                                                   logic [olpht_pkg::VAL_W-1:0] v);
      olpht_pkg::req_type r;
      r.func = f; r.hash_word = h; r.key = k; r.entry_value = v;
      return r;
   endfunction

   function automatic logic [olpht_pkg::HASH_W-1:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      olpht_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.slot_index !== want.slot_index ||
                rsp_data.read_value !== want.read_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected st=%0d slot=%0d val=%h, %s",
                           rsp_seen, want.status, want.slot_index, want.read_value,
                           $sformatf("got st=%0d slot=%0d val=%h", rsp_data.status,
                                     rsp_data.slot_index, rsp_data.read_value));
            end
         end
      end
   end

   task automatic test_directed();
      logic [olpht_pkg::HASH_W-1:0] h;
      h = 64'hFFFF_FFFF_FFFF_FFFF;
      send_request(make_req(olpht_pkg::FUNC_FIND, h, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, 64'h0, 32'h0, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_INSERT, h, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(olpht_pkg::FUNC_INSERT, 64'h0, 32'h0, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_INSERT, h, 32'h1234_5678, 32'hA5A5_A5A5));
      send_request(make_req(olpht_pkg::FUNC_FIND, h, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_FIND, h, 32'h1234_5678, 32'h0));
      send_request(make_req(FUNC_SPARE, h, 32'h1234_5678, 32'hDEAD_BEEF));
      // replace returns the old value
      send_request(make_req(olpht_pkg::FUNC_INSERT, h, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
      send_request(make_req(olpht_pkg::FUNC_INSERT, 64'hFF80_0000_0000_0000,
                            32'h77, 32'h1));
      send_request(make_req(olpht_pkg::FUNC_INSERT, 64'h0100_0000_0000_0000,
                            32'h88, 32'h2));
      send_request(make_req(olpht_pkg::FUNC_FIND, 64'h0, 32'h0, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, h, 32'hFFFF_FFFF, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_FIND, h, 32'h1234_5678, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, 64'h0, 32'h0, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, h, 32'h1234_5678, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, 64'hFF80_0000_0000_0000,
                            32'h77, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, 64'h0100_0000_0000_0000,
                            32'h88, 32'h0));
      send_request(make_req(olpht_pkg::FUNC_REMOVE, 64'h0100_0000_0000_0000,
                            32'h88, 32'h0));
   endtask

   // one home, 130 keys: the tail of the cluster runs into the distance limit
   task automatic test_distance_limit();
      logic [olpht_pkg::HASH_W-1:0] h;
      h = {8'hF0, 56'h0};
      for (int i = 0; i < 130; i++)
         send_request(make_req(olpht_pkg::FUNC_INSERT,
                               h | (64'($urandom_range(127)) << 49),
                               32'h1000 + i, $urandom));
      for (int i = 0; i < 130; i++)
         send_request(make_req(olpht_pkg::FUNC_REMOVE, h, 32'h1000 + i, 32'h0));
      for (int i = 0; i < olpht_pkg::SLOTS; i++) begin
         if (tags[i] != 0)
            send_request(make_req(olpht_pkg::FUNC_REMOVE, {tags[i][14:0], 49'h0},
                                  keys[i], 32'h0));
      end
   endtask

   task automatic test_saturate();
      for (int i = 0; i < olpht_pkg::SLOTS; i++)
         send_request(make_req(olpht_pkg::FUNC_INSERT, {8'(i), 56'($urandom)},
                               $urandom, $urandom));
      send_request(make_req(olpht_pkg::FUNC_INSERT, rand_hash(), $urandom, $urandom));
      send_request(make_req(olpht_pkg::FUNC_FIND, rand_hash(), $urandom, 32'h0));
      for (int i = 0; i < olpht_pkg::SLOTS; i++) begin
         if (tags[i] != 0)
            send_request(make_req(olpht_pkg::FUNC_REMOVE, {tags[i][14:0], 49'h0},
                                  keys[i], 32'h0));
      end
   endtask

   task automatic test_random(int count);
      int p;
      logic [olpht_pkg::FUNC_W-1:0] f;
      for (int i = 0; i < 64; i++) begin
         pool_key[i] = $urandom;
         pool_hash[i] = rand_hash();
         // crowd some homes together, with wrap near the top
         if (i % 2 == 0) pool_hash[i][63:56] = 8'hF8 + 8'($urandom_range(15));
         // share a full tag with a neighbor to force key compares
         if (i % 8 == 7) pool_hash[i] = pool_hash[i - 1];
      end
      for (int i = 0; i < count; i++) begin
         if (i == count - 200) idle_on = 1'b0;
         p = $urandom_range(63);
         f = 2'($urandom_range(2));
         if ($urandom_range(19) == 0) begin
            send_request(make_req(2'($urandom), rand_hash(), $urandom, $urandom));
         end else begin
            if ($urandom_range(2) == 0) f = olpht_pkg::FUNC_INSERT;
            send_request(make_req(f, pool_hash[p], pool_key[p], $urandom));
         end
      end
   endtask

   initial begin
      fill_count = 0;
      foreach (tags[i]) tags[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      test_directed();
      test_distance_limit();
      test_saturate();
      idle_on = 1'b1;
      test_random(500);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("%0d requests, %0d results: found %0d, inserted %0d, removed %0d,",
               req_sent, rsp_seen, op_tally[olpht_pkg::STAT_FOUND],
               op_tally[olpht_pkg::STAT_INSERTED], op_tally[olpht_pkg::STAT_REMOVED]);
      $display("absent %0d, full %0d; %0d mismatches",
               op_tally[olpht_pkg::STAT_ABSENT], op_tally[olpht_pkg::STAT_FULL],
               mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
sv/olpht_pkg.sv
sv/olpht_dp.sv
sv/olpht_ctrl.sv
sv/ordered_linear_probe_hash_table.sv
test/testbench.sv
